// ===== rtl/dqk_pkg.sv =====
package dqk_pkg;

  localparam int unsigned CapacityDef = 32;
  localparam int unsigned DataW       = 32;
  localparam int unsigned CmdW        = 3;
  localparam int unsigned StatusW     = 2;
  localparam int unsigned OccW        = 6;

  typedef enum logic [CmdW-1:0] {
    CmdPushFront = 3'd0,
    CmdPushBack  = 3'd1,
    CmdPopFront  = 3'd2,
    CmdPopBack   = 3'd3,
    CmdRemove    = 3'd4,
    CmdClear     = 3'd5,
    CmdList      = 3'd6
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    StOk       = 2'd0,
    StEmpty    = 2'd1,
    StNotFound = 2'd2,
    StFull     = 2'd3
  } status_e;

  // Per-cycle operation applied to every cell of the chain
  typedef enum logic [2:0] {
    OpHold,
    OpShiftRight,
    OpShiftLeft,
    OpRotateLeft,
    OpWriteTail
  } op_e;

  typedef enum logic [1:0] {
    SIdle,
    SRemove,
    SList
  } state_e;

endpackage

// ===== rtl/dqk_in_if.sv =====
interface dqk_in_if;
  logic                              valid;
  logic                              ready;
  logic [dqk_pkg::CmdW-1:0]          cmd;
  logic signed [dqk_pkg::DataW-1:0]  value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

// ===== rtl/dqk_out_if.sv =====
interface dqk_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [dqk_pkg::DataW-1:0]  value_res;
  logic [dqk_pkg::StatusW-1:0]       status;
  logic [dqk_pkg::OccW-1:0]          occupancy;
  logic                              last;

  modport source (output valid, output value_res, output status, output occupancy,
                  output last, input ready);
  modport sink   (input valid, input value_res, input status, input occupancy,
                  input last, output ready);
endinterface

// ===== rtl/deque_with_key_removal_top.sv =====
// Double-ended queue of up to CAPACITY signed 32-bit entries, held in a row of cells with the
// front in cell 0. Push front/back, pop front/back and clear take one item per cycle: the
// result is registered and the next item is accepted as soon as the output register is free.
// Remove by key rotates the row once through cell 0, comparing each entry with the key and
// dropping the first match, then gives its single result once the output register is free. List
// rotates the row the same way and streams one entry per cycle while the output register is
// free, count results, the last one marked. A push into a full queue is dropped with status
// full; pops, remove, clear and list on an empty queue give status empty. Occupancy is the
// entry count after the item, low six bits.
module deque_with_key_removal_top #(
  parameter int unsigned CAPACITY = dqk_pkg::CapacityDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  dqk_in_if.sink    in_i,
  dqk_out_if.source res_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam logic [CntW-1:0] CapC = CntW'(CAPACITY);
  localparam logic [CntW-1:0] OneC = CntW'(1);

  dqk_pkg::state_e state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] rem_q, rem_d;
  logic            found_q, found_d;
  logic [dqk_pkg::DataW-1:0] key_q, key_d;

  logic                         out_valid_q;
  logic [dqk_pkg::DataW-1:0]    out_value_q;
  dqk_pkg::status_e             out_status_q;
  logic [dqk_pkg::OccW-1:0]     out_occ_q;
  logic                         out_last_q;

  logic                         emit;
  logic [dqk_pkg::DataW-1:0]    e_value;
  dqk_pkg::status_e             e_status;
  logic                         e_last;
  logic                         out_free;
  logic                         in_ready;
  logic                         accept;
  dqk_pkg::op_e                 op;
  logic [dqk_pkg::DataW-1:0]    din;
  logic [dqk_pkg::DataW-1:0]    head;
  logic [dqk_pkg::DataW-1:0]    tail;

  logic [dqk_pkg::DataW-1:0]    cell_data [CAPACITY];
  logic [dqk_pkg::DataW-1:0]    cell_tail [CAPACITY];

  assign din  = $unsigned(in_i.value);
  assign head = cell_data[0];

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [dqk_pkg::DataW-1:0] prev, next;
    if (g == 0) begin : g_first
      assign prev = din;
    end else begin : g_mid
      assign prev = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_end
      assign next = '0;
    end else begin : g_inner
      assign next = cell_data[g+1];
    end

    dqk_cell #(
      .Idx  (g),
      .CntW (CntW)
    ) u_cell (
      .clk_i   (clk_i),
      .op_i    (op),
      .count_i (count_q),
      .din_i   (din),
      .prev_i  (prev),
      .next_i  (next),
      .head_i  (head),
      .data_o  (cell_data[g]),
      .tail_o  (cell_tail[g])
    );
  end

  always_comb begin
    tail = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      tail = tail | cell_tail[i];
    end
  end

  assign out_free = !out_valid_q || res_o.ready;
  assign in_ready = (state_q == dqk_pkg::SIdle) && out_free;
  assign accept   = in_i.valid && in_ready;

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    rem_d    = rem_q;
    found_d  = found_q;
    key_d    = key_q;
    op       = dqk_pkg::OpHold;
    emit     = 1'b0;
    e_value  = '0;
    e_status = dqk_pkg::StOk;
    e_last   = 1'b1;

    unique case (state_q)
      dqk_pkg::SIdle: begin
        if (accept) begin
          emit = 1'b1;
          unique case (dqk_pkg::cmd_e'(in_i.cmd))
            dqk_pkg::CmdPushFront, dqk_pkg::CmdPushBack: begin
              if (count_q == CapC) begin
                e_status = dqk_pkg::StFull;
              end else begin
                op = (dqk_pkg::cmd_e'(in_i.cmd) == dqk_pkg::CmdPushFront) ?
                     dqk_pkg::OpShiftRight : dqk_pkg::OpWriteTail;
                count_d = count_q + OneC;
              end
            end
            dqk_pkg::CmdPopFront: begin
              if (count_q == '0) begin
                e_status = dqk_pkg::StEmpty;
              end else begin
                e_value = head;
                op      = dqk_pkg::OpShiftLeft;
                count_d = count_q - OneC;
              end
            end
            dqk_pkg::CmdPopBack: begin
              if (count_q == '0) begin
                e_status = dqk_pkg::StEmpty;
              end else begin
                e_value = tail;
                count_d = count_q - OneC;
              end
            end
            dqk_pkg::CmdRemove: begin
              if (count_q == '0) begin
                e_status = dqk_pkg::StEmpty;
              end else begin
                emit    = 1'b0;
                rem_d   = count_q;
                found_d = 1'b0;
                key_d   = din;
                state_d = dqk_pkg::SRemove;
              end
            end
            dqk_pkg::CmdClear: begin
              if (count_q == '0) e_status = dqk_pkg::StEmpty;
              else count_d = '0;
            end
            dqk_pkg::CmdList: begin
              if (count_q == '0) begin
                e_status = dqk_pkg::StEmpty;
              end else begin
                emit    = 1'b0;
                rem_d   = count_q;
                state_d = dqk_pkg::SList;
              end
            end
            default: ;
          endcase
        end
      end
      dqk_pkg::SRemove: begin
        // hold the final step until the result has somewhere to go
        if (rem_q != OneC || out_free) begin
          if (!found_q && head == key_q) begin
            op      = dqk_pkg::OpShiftLeft;
            count_d = count_q - OneC;
            found_d = 1'b1;
          end else begin
            op = dqk_pkg::OpRotateLeft;
          end
          rem_d = rem_q - OneC;
          if (rem_q == OneC) begin
            emit     = 1'b1;
            e_status = found_d ? dqk_pkg::StOk : dqk_pkg::StNotFound;
            state_d  = dqk_pkg::SIdle;
          end
        end
      end
      dqk_pkg::SList: begin
        if (out_free) begin
          emit    = 1'b1;
          e_value = head;
          e_last  = (rem_q == OneC);
          op      = dqk_pkg::OpRotateLeft;
          rem_d   = rem_q - OneC;
          if (rem_q == OneC) state_d = dqk_pkg::SIdle;
        end
      end
      default: state_d = dqk_pkg::SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dqk_pkg::SIdle;
      count_q     <= '0;
      rem_q       <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      rem_q   <= rem_d;
      found_q <= found_d;
      if (emit) out_valid_q <= 1'b1;
      else if (res_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    if (emit) begin
      out_value_q  <= e_value;
      out_status_q <= e_status;
      out_occ_q    <= dqk_pkg::OccW'(count_d);
      out_last_q   <= e_last;
    end
  end

  assign in_i.ready      = in_ready;
  assign res_o.valid     = out_valid_q;
  assign res_o.value_res = $signed(out_value_q);
  assign res_o.status    = out_status_q;
  assign res_o.occupancy = out_occ_q;
  assign res_o.last      = out_last_q;

endmodule

// ===== rtl/dqk_cell.sv =====
module dqk_cell #(
  parameter int unsigned Idx  = 0,
  parameter int unsigned CntW = 6
) (
  input  logic                       clk_i,
  input  dqk_pkg::op_e               op_i,
  input  logic [CntW-1:0]            count_i,
  input  logic [dqk_pkg::DataW-1:0]  din_i,
  input  logic [dqk_pkg::DataW-1:0]  prev_i,
  input  logic [dqk_pkg::DataW-1:0]  next_i,
  input  logic [dqk_pkg::DataW-1:0]  head_i,
  output logic [dqk_pkg::DataW-1:0]  data_o,
  output logic [dqk_pkg::DataW-1:0]  tail_o
);

  localparam logic [CntW-1:0] IdxC   = CntW'(Idx);
  localparam logic [CntW-1:0] IdxP1C = CntW'(Idx + 1);

  logic [dqk_pkg::DataW-1:0] data_q, data_d;
  logic                      is_tail;

  assign is_tail = (IdxP1C == count_i);

  always_comb begin
    data_d = data_q;
    unique case (op_i)
      dqk_pkg::OpShiftRight: data_d = prev_i;
      dqk_pkg::OpShiftLeft: begin
        if (IdxP1C < count_i) data_d = next_i;
      end
      dqk_pkg::OpRotateLeft: begin
        // tail wraps round to take the head, the rest move one place forward
        if (is_tail) data_d = head_i;
        else if (IdxC < count_i) data_d = next_i;
      end
      dqk_pkg::OpWriteTail: begin
        if (IdxC == count_i) data_d = din_i;
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign tail_o = is_tail ? data_q : '0;

endmodule
